/* rtl/vna_pkg.sv */
// Shared types, codes and constants for the vertex normal accumulator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package vna_pkg;

   // Parameter defaults
   localparam int MAX_VERTICES_DEF = 1024;
   localparam int COORD_BITS_DEF   = 24;
   localparam int ACC_BITS_DEF     = 56;

   // Fixed field widths
   localparam int OPCODE_W = 2;
   localparam int INDEX_W  = 10;
   localparam int COUNT_W  = 11;
   localparam int NORMAL_W = 16;
   localparam int STATUS_W = 2;

   // Normalization datapath
   localparam int NORM_TOP = 29;                  // top bit of the largest magnitude
   localparam int MAG_W    = NORM_TOP + 1;
   localparam int SUM_W    = 64;                  // sum of squares, square root work
   localparam int LEN_W    = MAG_W + 1;           // vector length
   localparam int FRAC_W   = 15;                  // Q1.15 result
   localparam int QUO_W    = FRAC_W + 2;          // quotient bits, holds 2^15
   localparam int NUM_W    = MAG_W + FRAC_W + 1;  // dividend with rounding term
   localparam int QMAX     = (1 << FRAC_W) - 1;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_LOAD = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_TRI  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_NONE = 2'd3;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_TRI,
      CMD_READ,
      CMD_ERR
   } cmd_kind_type;

   // Classified item between front and back
   typedef struct packed {
      cmd_kind_type         kind;
      logic [INDEX_W-1:0]   index_a;
      logic [INDEX_W-1:0]   index_b;
      logic [INDEX_W-1:0]   index_c;
   } cmd_type;

   typedef struct packed {
      logic [INDEX_W-1:0]         vertex_index;
      logic signed [NORMAL_W-1:0] normal_x;
      logic signed [NORMAL_W-1:0] normal_y;
      logic signed [NORMAL_W-1:0] normal_z;
      logic [STATUS_W-1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic signed [NORMAL_W-1:0] normal_x;
      logic signed [NORMAL_W-1:0] normal_y;
      logic signed [NORMAL_W-1:0] normal_z;
      logic                       zero;
   } norm_result_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_ERR,
      ST_TRI_V0,
      ST_TRI_V1,
      ST_TRI_V2,
      ST_TRI_V3,
      ST_MUL,
      ST_CROSS,
      ST_ACC_RD,
      ST_ACC_WR,
      ST_READ_RD,
      ST_READ_GO,
      ST_READ_WAIT,
      ST_PUSH
   } back_state_type;

   typedef enum logic [2:0] {
      N_IDLE,
      N_SHIFT,
      N_SQUARE,
      N_SQRT,
      N_DIV_INIT,
      N_DIV_STEP,
      N_DIV_END,
      N_DONE
   } norm_state_type;

endpackage

`default_nettype wire

/* rtl/vna_front.sv */
// Front end: vertex_count register, index checks, item classification and
// a two-entry command queue to the back end. Depends on vna_pkg.
`default_nettype none

module vna_front #(
   parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF,
   parameter int COORD_BITS   = vna_pkg::COORD_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   output logic                                full,
   input  wire logic [vna_pkg::OPCODE_W-1:0]   req_opcode,
   input  wire logic [vna_pkg::INDEX_W-1:0]    req_index_a,
   input  wire logic [vna_pkg::INDEX_W-1:0]    req_index_b,
   input  wire logic [vna_pkg::INDEX_W-1:0]    req_index_c,
   input  wire logic signed [COORD_BITS-1:0]   req_coord_x,
   input  wire logic signed [COORD_BITS-1:0]   req_coord_y,
   input  wire logic signed [COORD_BITS-1:0]   req_coord_z,
   input  wire logic                           csr_wr_en,
   input  wire logic [vna_pkg::COUNT_W-1:0]    csr_wr_data,
   input  wire logic                           clear_busy,
   output logic                                cmd_valid,
   output vna_pkg::cmd_type                    cmd,
   output logic [3*COORD_BITS-1:0]             cmd_coords,
   input  wire logic                           cmd_pop
);
   import vna_pkg::*;

   logic [COUNT_W-1:0]      vcount_ff;
   logic                    ia_ok, ib_ok, ic_ok;
   logic                    accept, enq;
   cmd_type                 cmd_in;
   cmd_type                 cmd_q_ff [2];
   logic [3*COORD_BITS-1:0] crd_q_ff [2];
   logic [1:0]              count_ff, count_in;
   logic                    wr_ff, rd_ff;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= '0;
      end else if (csr_wr_en) begin
         vcount_ff <= csr_wr_data;
      end
   end

   // Index checks against vertex_count and the store depth
   always_comb begin
      ia_ok = (32'(req_index_a) < 32'(vcount_ff)) && (32'(req_index_a) < MAX_VERTICES);
      ib_ok = (32'(req_index_b) < 32'(vcount_ff)) && (32'(req_index_b) < MAX_VERTICES);
      ic_ok = (32'(req_index_c) < 32'(vcount_ff)) && (32'(req_index_c) < MAX_VERTICES);
   end

   // Classification; the unused opcode is taken and dropped
   always_comb begin
      cmd_in.index_a = req_index_a;
      cmd_in.index_b = req_index_b;
      cmd_in.index_c = req_index_c;
      unique case (req_opcode)
         OP_LOAD: cmd_in.kind = ia_ok ? CMD_LOAD : CMD_ERR;
         OP_TRI:  cmd_in.kind = (ia_ok && ib_ok && ic_ok) ? CMD_TRI : CMD_ERR;
         OP_READ: cmd_in.kind = ia_ok ? CMD_READ : CMD_ERR;
         default: cmd_in.kind = CMD_ERR;
      endcase
   end

   assign full   = (count_ff == 2'd2) || clear_busy;
   assign accept = push && !full;
   assign enq    = accept && (req_opcode != OP_NONE);

   // Command queue
   assign cmd_valid  = (count_ff != 2'd0);
   assign cmd        = cmd_q_ff[rd_ff];
   assign cmd_coords = crd_q_ff[rd_ff];

   always_comb begin
      count_in = count_ff + {1'b0, enq} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (enq) begin
            wr_ff <= !wr_ff;
         end
         if (cmd_pop) begin
            rd_ff <= !rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         cmd_q_ff[wr_ff] <= cmd_in;
         crd_q_ff[wr_ff] <= {req_coord_x, req_coord_y, req_coord_z};
      end
   end

endmodule

`default_nettype wire

/* rtl/vna_norm.sv */
// Normalization unit: scales an accumulated normal to a Q1.15 unit vector
// with a shift loop, squares, a bit-pair square root and long division.
// Depends on vna_pkg.
`default_nettype none

module vna_norm #(
   parameter int ACC_BITS = vna_pkg::ACC_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [ACC_BITS-1:0]   acc_x,
   input  wire logic [ACC_BITS-1:0]   acc_y,
   input  wire logic [ACC_BITS-1:0]   acc_z,
   output logic                       done,
   output vna_pkg::norm_result_type   result
);
   import vna_pkg::*;

   norm_state_type             state_ff, state_in;
   logic [ACC_BITS-1:0]        mag_ff [3];
   logic [ACC_BITS-1:0]        acc_in [3];
   logic                       neg_ff [3];
   logic [1:0]                 k_ff;
   logic [4:0]                 step_ff;
   logic [SUM_W-1:0]           sq_ff, sum_ff, v_ff, r_ff, bit_ff;
   logic [SUM_W-1:0]           rb, r_next;
   logic                       v_ge;
   logic [LEN_W-1:0]           len_ff, rem_ff;
   logic [QUO_W-1:0]           num_ff, quo_ff;
   logic signed [NORMAL_W-1:0] res_ff [3];
   logic                       zero_ff;
   logic [ACC_BITS-1:0]        orv;
   logic                       mag_hi, mag_top, mag_zero;
   logic [MAG_W-1:0]           mag_sel;
   logic [2*MAG_W-1:0]         sq_p;
   logic [NUM_W-1:0]           numer;
   logic [LEN_W:0]             trial;
   logic                       q_ge;
   logic [NORMAL_W-1:0]        q_lim;

   assign acc_in[0] = acc_x;
   assign acc_in[1] = acc_y;
   assign acc_in[2] = acc_z;

   // Shift loop status
   always_comb begin
      orv      = mag_ff[0] | mag_ff[1] | mag_ff[2];
      mag_hi   = |(orv >> MAG_W);
      mag_top  = orv[NORM_TOP];
      mag_zero = (orv == '0);
   end

   // Shared square, root step and divide step
   always_comb begin
      unique case (k_ff)
         2'd0:    mag_sel = mag_ff[0][MAG_W-1:0];
         2'd1:    mag_sel = mag_ff[1][MAG_W-1:0];
         default: mag_sel = mag_ff[2][MAG_W-1:0];
      endcase
      sq_p   = mag_sel * mag_sel;
      rb     = r_ff + bit_ff;
      v_ge   = (v_ff >= rb);
      r_next = v_ge ? ((r_ff >> 1) + bit_ff) : (r_ff >> 1);
      numer  = {1'b0, mag_sel, {FRAC_W{1'b0}}} + NUM_W'(len_ff >> 1);
      trial  = {rem_ff, num_ff[QUO_W-1]};
      q_ge   = (trial >= {1'b0, len_ff});
      q_lim  = (quo_ff > QUO_W'(QMAX)) ? NORMAL_W'(QMAX) : quo_ff[NORMAL_W-1:0];
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      done     = 1'b0;
      unique case (state_ff)
         N_IDLE: begin
            if (start) begin
               state_in = N_SHIFT;
            end
         end
         N_SHIFT: begin
            if (mag_zero) begin
               state_in = N_DONE;
            end else if (!mag_hi && mag_top) begin
               state_in = N_SQUARE;
            end
         end
         N_SQUARE: begin
            if (k_ff == 2'd3) begin
               state_in = N_SQRT;
            end
         end
         N_SQRT: begin
            if (bit_ff[0]) begin
               state_in = N_DIV_INIT;
            end
         end
         N_DIV_INIT: state_in = N_DIV_STEP;
         N_DIV_STEP: begin
            if (step_ff == 5'(QUO_W - 1)) begin
               state_in = N_DIV_END;
            end
         end
         N_DIV_END: state_in = (k_ff == 2'd2) ? N_DONE : N_DIV_INIT;
         N_DONE: begin
            done     = 1'b1;
            state_in = N_IDLE;
         end
         default: state_in = N_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         k_ff     <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            N_SHIFT:    k_ff <= '0;
            N_SQUARE:   k_ff <= (k_ff == 2'd3) ? 2'd0 : k_ff + 2'd1;
            N_DIV_INIT: step_ff <= '0;
            N_DIV_STEP: step_ff <= step_ff + 5'd1;
            N_DIV_END:  k_ff <= k_ff + 2'd1;
            default: begin
            end
         endcase
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         N_IDLE: begin
            if (start) begin
               zero_ff <= 1'b0;
               for (int i = 0; i < 3; i++) begin
                  neg_ff[i] <= acc_in[i][ACC_BITS-1];
                  mag_ff[i] <= acc_in[i][ACC_BITS-1] ? -acc_in[i] : acc_in[i];
               end
            end
         end
         N_SHIFT: begin
            if (mag_zero) begin
               zero_ff <= 1'b1;
               for (int i = 0; i < 3; i++) begin
                  res_ff[i] <= '0;
               end
            end else if (mag_hi) begin
               for (int i = 0; i < 3; i++) begin
                  mag_ff[i] <= mag_ff[i] >> 1;
               end
            end else if (!mag_top) begin
               for (int i = 0; i < 3; i++) begin
                  mag_ff[i] <= mag_ff[i] << 1;
               end
            end
         end
         N_SQUARE: begin
            sq_ff <= SUM_W'(sq_p);
            if (k_ff == 2'd0) begin
               sum_ff <= '0;
            end else begin
               sum_ff <= sum_ff + sq_ff;
            end
            if (k_ff == 2'd3) begin
               v_ff   <= sum_ff + sq_ff;
               r_ff   <= '0;
               bit_ff <= SUM_W'(1) << (SUM_W - 2);
            end
         end
         N_SQRT: begin
            if (v_ge) begin
               v_ff <= v_ff - rb;
            end
            r_ff   <= r_next;
            bit_ff <= bit_ff >> 2;
            if (bit_ff[0]) begin
               len_ff <= LEN_W'(r_next);
            end
         end
         N_DIV_INIT: begin
            rem_ff <= LEN_W'(numer >> QUO_W);
            num_ff <= numer[QUO_W-1:0];
            quo_ff <= '0;
         end
         N_DIV_STEP: begin
            rem_ff <= q_ge ? LEN_W'(trial - {1'b0, len_ff}) : LEN_W'(trial);
            num_ff <= num_ff << 1;
            quo_ff <= {quo_ff[QUO_W-2:0], q_ge};
         end
         N_DIV_END: begin
            res_ff[k_ff] <= neg_ff[k_ff] ? -$signed(q_lim) : $signed(q_lim);
         end
         default: begin
         end
      endcase
   end

   assign result.normal_x = res_ff[0];
   assign result.normal_y = res_ff[1];
   assign result.normal_z = res_ff[2];
   assign result.zero     = zero_ff;

endmodule

`default_nettype wire

/* rtl/vna_back.sv */
// Back end: vertex and accumulator memories, the sequencer that runs each
// command, the cross product multiplier and the result queue.
// Depends on vna_pkg and vna_norm.
`default_nettype none

module vna_back #(
   parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF,
   parameter int COORD_BITS   = vna_pkg::COORD_BITS_DEF,
   parameter int ACC_BITS     = vna_pkg::ACC_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             cmd_valid,
   input  wire vna_pkg::cmd_type                 cmd,
   input  wire logic [3*COORD_BITS-1:0]          cmd_coords,
   output logic                                  cmd_pop,
   output logic                                  clear_busy,
   output logic                                  empty,
   input  wire logic                             pop,
   output logic [vna_pkg::INDEX_W-1:0]           rsp_vertex_index,
   output logic signed [vna_pkg::NORMAL_W-1:0]   rsp_normal_x,
   output logic signed [vna_pkg::NORMAL_W-1:0]   rsp_normal_y,
   output logic signed [vna_pkg::NORMAL_W-1:0]   rsp_normal_z,
   output logic [vna_pkg::STATUS_W-1:0]          rsp_status
);
   import vna_pkg::*;

   localparam int ADDR_W  = $clog2(MAX_VERTICES);
   localparam int DIFF_W  = COORD_BITS + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int CROSS_W = PROD_W + 1;

   back_state_type            state_ff, state_in;
   cmd_type                   cur_ff;
   logic [3*COORD_BITS-1:0]   cur_crd_ff;

   // Memories
   logic [COORD_BITS-1:0]     vx_mem [MAX_VERTICES];
   logic [COORD_BITS-1:0]     vy_mem [MAX_VERTICES];
   logic [COORD_BITS-1:0]     vz_mem [MAX_VERTICES];
   logic [ACC_BITS-1:0]       ax_mem [MAX_VERTICES];
   logic [ACC_BITS-1:0]       ay_mem [MAX_VERTICES];
   logic [ACC_BITS-1:0]       az_mem [MAX_VERTICES];
   logic                      v_we, a_we;
   logic [ADDR_W-1:0]         v_addr, a_waddr, a_raddr;
   logic [3*ACC_BITS-1:0]     a_wdata;
   logic [COORD_BITS-1:0]     vx_rd_ff, vy_rd_ff, vz_rd_ff;
   logic [ACC_BITS-1:0]       ax_rd_ff, ay_rd_ff, az_rd_ff;

   // Triangle datapath
   logic [3*COORD_BITS-1:0]   v0_ff, v1_ff;
   logic signed [DIFF_W-1:0]  ea_ff [3];
   logic signed [DIFF_W-1:0]  eb_ff [3];
   logic signed [PROD_W-1:0]  prod_ff [6];
   logic signed [DIFF_W-1:0]  mul_l, mul_r;
   logic signed [PROD_W-1:0]  mul_p;
   logic signed [CROSS_W-1:0] cx, cy, cz;
   logic [ACC_BITS-1:0]       cross_ff [3];
   logic [2:0]                mul_k_ff;
   logic [1:0]                corner_ff;
   logic [INDEX_W-1:0]        corner_idx;
   logic [ADDR_W-1:0]         clr_ff;

   // Normalization and results
   logic                      norm_start, norm_done;
   norm_result_type           norm_res;
   rsp_type                   res_ff, res_in;
   logic                      res_load, rsp_push;
   rsp_type                   rsp_q_ff [2];
   logic [1:0]                rsp_count_ff;
   logic                      rsp_wr_ff, rsp_rd_ff, rsp_take;

   vna_norm #(
      .ACC_BITS (ACC_BITS)
   ) u_norm (
      .clock  (clock),
      .reset  (reset),
      .start  (norm_start),
      .acc_x  (ax_rd_ff),
      .acc_y  (ay_rd_ff),
      .acc_z  (az_rd_ff),
      .done   (norm_done),
      .result (norm_res)
   );

   // Corner select for accumulator updates
   always_comb begin
      unique case (corner_ff)
         2'd0:    corner_idx = cur_ff.index_a;
         2'd1:    corner_idx = cur_ff.index_b;
         default: corner_idx = cur_ff.index_c;
      endcase
   end

   // Multiplier operand select: a1b2, a2b1, a2b0, a0b2, a0b1, a1b0
   always_comb begin
      unique case (mul_k_ff)
         3'd0: begin mul_l = ea_ff[1]; mul_r = eb_ff[2]; end
         3'd1: begin mul_l = ea_ff[2]; mul_r = eb_ff[1]; end
         3'd2: begin mul_l = ea_ff[2]; mul_r = eb_ff[0]; end
         3'd3: begin mul_l = ea_ff[0]; mul_r = eb_ff[2]; end
         3'd4: begin mul_l = ea_ff[0]; mul_r = eb_ff[1]; end
         3'd5: begin mul_l = ea_ff[1]; mul_r = eb_ff[0]; end
         default: begin mul_l = '0; mul_r = '0; end
      endcase
      mul_p = mul_l * mul_r;
      cx    = CROSS_W'(prod_ff[0]) - CROSS_W'(prod_ff[1]);
      cy    = CROSS_W'(prod_ff[2]) - CROSS_W'(prod_ff[3]);
      cz    = CROSS_W'(prod_ff[4]) - CROSS_W'(prod_ff[5]);
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      cmd_pop    = 1'b0;
      v_we       = 1'b0;
      v_addr     = ADDR_W'(cur_ff.index_a);
      a_we       = 1'b0;
      a_waddr    = ADDR_W'(corner_idx);
      a_wdata    = '0;
      a_raddr    = ADDR_W'(corner_idx);
      norm_start = 1'b0;
      res_load   = 1'b0;
      rsp_push   = 1'b0;
      res_in     = res_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            a_we    = 1'b1;
            a_waddr = clr_ff;
            if (clr_ff == ADDR_W'(MAX_VERTICES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               unique case (cmd.kind)
                  CMD_LOAD: state_in = ST_LOAD;
                  CMD_TRI:  state_in = ST_TRI_V0;
                  CMD_READ: state_in = ST_READ_RD;
                  default:  state_in = ST_ERR;
               endcase
            end
         end
         ST_LOAD: begin
            v_we     = 1'b1;
            a_we     = 1'b1;
            a_waddr  = ADDR_W'(cur_ff.index_a);
            state_in = ST_IDLE;
         end
         ST_ERR: begin
            res_load            = 1'b1;
            res_in.vertex_index = cur_ff.index_a;
            res_in.normal_x     = '0;
            res_in.normal_y     = '0;
            res_in.normal_z     = '0;
            res_in.status       = STATUS_RANGE;
            state_in            = ST_PUSH;
         end
         ST_TRI_V0: state_in = ST_TRI_V1;
         ST_TRI_V1: begin
            v_addr   = ADDR_W'(cur_ff.index_b);
            state_in = ST_TRI_V2;
         end
         ST_TRI_V2: begin
            v_addr   = ADDR_W'(cur_ff.index_c);
            state_in = ST_TRI_V3;
         end
         ST_TRI_V3: state_in = ST_MUL;
         ST_MUL: begin
            if (mul_k_ff == 3'd5) begin
               state_in = ST_CROSS;
            end
         end
         ST_CROSS: state_in = ST_ACC_RD;
         ST_ACC_RD: state_in = ST_ACC_WR;
         ST_ACC_WR: begin
            a_we    = 1'b1;
            a_wdata = {ax_rd_ff + cross_ff[0], ay_rd_ff + cross_ff[1],
                       az_rd_ff + cross_ff[2]};
            if (corner_ff == 2'd2) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_ACC_RD;
            end
         end
         ST_READ_RD: begin
            a_raddr  = ADDR_W'(cur_ff.index_a);
            state_in = ST_READ_GO;
         end
         ST_READ_GO: begin
            norm_start = 1'b1;
            state_in   = ST_READ_WAIT;
         end
         ST_READ_WAIT: begin
            if (norm_done) begin
               res_load            = 1'b1;
               res_in.vertex_index = cur_ff.index_a;
               res_in.normal_x     = norm_res.normal_x;
               res_in.normal_y     = norm_res.normal_y;
               res_in.normal_z     = norm_res.normal_z;
               res_in.status       = norm_res.zero ? STATUS_ZERO : STATUS_OK;
               state_in            = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (rsp_count_ff != 2'd2) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign clear_busy = (state_ff == ST_CLEAR);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         mul_k_ff  <= '0;
         corner_ff <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_CLEAR:  clr_ff <= clr_ff + ADDR_W'(1);
            ST_TRI_V3: mul_k_ff <= '0;
            ST_MUL:    mul_k_ff <= mul_k_ff + 3'd1;
            ST_CROSS:  corner_ff <= '0;
            ST_ACC_WR: corner_ff <= corner_ff + 2'd1;
            default: begin
            end
         endcase
      end
   end

   // Command and triangle datapath registers
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cur_ff     <= cmd;
         cur_crd_ff <= cmd_coords;
      end
      if (state_ff == ST_TRI_V1) begin
         v0_ff <= {vx_rd_ff, vy_rd_ff, vz_rd_ff};
      end
      if (state_ff == ST_TRI_V2) begin
         v1_ff <= {vx_rd_ff, vy_rd_ff, vz_rd_ff};
      end
      if (state_ff == ST_TRI_V3) begin
         ea_ff[0] <= DIFF_W'($signed(v1_ff[3*COORD_BITS-1:2*COORD_BITS]))
                   - DIFF_W'($signed(v0_ff[3*COORD_BITS-1:2*COORD_BITS]));
         ea_ff[1] <= DIFF_W'($signed(v1_ff[2*COORD_BITS-1:COORD_BITS]))
                   - DIFF_W'($signed(v0_ff[2*COORD_BITS-1:COORD_BITS]));
         ea_ff[2] <= DIFF_W'($signed(v1_ff[COORD_BITS-1:0]))
                   - DIFF_W'($signed(v0_ff[COORD_BITS-1:0]));
         eb_ff[0] <= DIFF_W'($signed(vx_rd_ff))
                   - DIFF_W'($signed(v0_ff[3*COORD_BITS-1:2*COORD_BITS]));
         eb_ff[1] <= DIFF_W'($signed(vy_rd_ff))
                   - DIFF_W'($signed(v0_ff[2*COORD_BITS-1:COORD_BITS]));
         eb_ff[2] <= DIFF_W'($signed(vz_rd_ff))
                   - DIFF_W'($signed(v0_ff[COORD_BITS-1:0]));
      end
      if (state_ff == ST_MUL) begin
         prod_ff[mul_k_ff] <= mul_p;
      end
      if (state_ff == ST_CROSS) begin
         cross_ff[0] <= ACC_BITS'(cx);
         cross_ff[1] <= ACC_BITS'(cy);
         cross_ff[2] <= ACC_BITS'(cz);
      end
      if (res_load) begin
         res_ff <= res_in;
      end
   end

   // Vertex memory, one port
   always_ff @(posedge clock) begin
      if (v_we) begin
         vx_mem[v_addr] <= cur_crd_ff[3*COORD_BITS-1:2*COORD_BITS];
         vy_mem[v_addr] <= cur_crd_ff[2*COORD_BITS-1:COORD_BITS];
         vz_mem[v_addr] <= cur_crd_ff[COORD_BITS-1:0];
      end
      vx_rd_ff <= vx_mem[v_addr];
      vy_rd_ff <= vy_mem[v_addr];
      vz_rd_ff <= vz_mem[v_addr];
   end

   // Accumulator memory, one write and one read port
   always_ff @(posedge clock) begin
      if (a_we) begin
         ax_mem[a_waddr] <= a_wdata[3*ACC_BITS-1:2*ACC_BITS];
         ay_mem[a_waddr] <= a_wdata[2*ACC_BITS-1:ACC_BITS];
         az_mem[a_waddr] <= a_wdata[ACC_BITS-1:0];
      end
      ax_rd_ff <= ax_mem[a_raddr];
      ay_rd_ff <= ay_mem[a_raddr];
      az_rd_ff <= az_mem[a_raddr];
   end

   // Result queue
   assign empty    = (rsp_count_ff == 2'd0);
   assign rsp_take = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_count_ff <= '0;
         rsp_wr_ff    <= 1'b0;
         rsp_rd_ff    <= 1'b0;
      end else begin
         rsp_count_ff <= rsp_count_ff + {1'b0, rsp_push} - {1'b0, rsp_take};
         if (rsp_push) begin
            rsp_wr_ff <= !rsp_wr_ff;
         end
         if (rsp_take) begin
            rsp_rd_ff <= !rsp_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         rsp_q_ff[rsp_wr_ff] <= res_ff;
      end
   end

   assign rsp_vertex_index = rsp_q_ff[rsp_rd_ff].vertex_index;
   assign rsp_normal_x     = rsp_q_ff[rsp_rd_ff].normal_x;
   assign rsp_normal_y     = rsp_q_ff[rsp_rd_ff].normal_y;
   assign rsp_normal_z     = rsp_q_ff[rsp_rd_ff].normal_z;
   assign rsp_status       = rsp_q_ff[rsp_rd_ff].status;

endmodule

`default_nettype wire

/* rtl/vertex_normal_accumulator_core.sv */
// Top level of the vertex normal accumulator: front end, back end.
// Depends on vna_pkg, vna_front and vna_back.
//
// Area-weighted vertex normals in fixed point. Items go in through a queue
// style port (push/full) and results come out of one (empty/pop); the front
// checks indices against vertex_count and queues up to two commands, so new
// items are taken while the back end works. After reset the accumulator
// memory is cleared one entry a cycle, with full held high. The back end's
// sequencer over a single-ported vertex memory and a one-write, one-read
// accumulator memory runs one command at a time: a load, an out-of-range item
// plus its result transfer, or a triangle (three vertex reads, six products on
// one multiplier, three accumulator read-modify-writes). A read waits on the
// normalization unit: one bit of shift per cycle to bring the largest
// component to bit 29, three squares, 32 square root steps and three 17-step
// divisions.
`default_nettype none

module vertex_normal_accumulator_core #(
   parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF,
   parameter int COORD_BITS   = vna_pkg::COORD_BITS_DEF,
   parameter int ACC_BITS     = vna_pkg::ACC_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             push,
   output logic                                  full,
   input  wire logic [vna_pkg::OPCODE_W-1:0]     req_opcode,
   input  wire logic [vna_pkg::INDEX_W-1:0]      req_index_a,
   input  wire logic [vna_pkg::INDEX_W-1:0]      req_index_b,
   input  wire logic [vna_pkg::INDEX_W-1:0]      req_index_c,
   input  wire logic signed [COORD_BITS-1:0]     req_coord_x,
   input  wire logic signed [COORD_BITS-1:0]     req_coord_y,
   input  wire logic signed [COORD_BITS-1:0]     req_coord_z,
   output logic                                  empty,
   input  wire logic                             pop,
   output logic [vna_pkg::INDEX_W-1:0]           rsp_vertex_index,
   output logic signed [vna_pkg::NORMAL_W-1:0]   rsp_normal_x,
   output logic signed [vna_pkg::NORMAL_W-1:0]   rsp_normal_y,
   output logic signed [vna_pkg::NORMAL_W-1:0]   rsp_normal_z,
   output logic [vna_pkg::STATUS_W-1:0]          rsp_status,
   input  wire logic                             csr_wr_en,
   input  wire logic [vna_pkg::COUNT_W-1:0]      csr_wr_data
);
   import vna_pkg::*;

   logic                    clear_busy;
   logic                    cmd_valid, cmd_pop;
   cmd_type                 cmd;
   logic [3*COORD_BITS-1:0] cmd_coords;

   vna_front #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_opcode  (req_opcode),
      .req_index_a (req_index_a),
      .req_index_b (req_index_b),
      .req_index_c (req_index_c),
      .req_coord_x (req_coord_x),
      .req_coord_y (req_coord_y),
      .req_coord_z (req_coord_z),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .clear_busy  (clear_busy),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_coords  (cmd_coords),
      .cmd_pop     (cmd_pop)
   );

   vna_back #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS),
      .ACC_BITS     (ACC_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_coords       (cmd_coords),
      .cmd_pop          (cmd_pop),
      .clear_busy       (clear_busy),
      .empty            (empty),
      .pop              (pop),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_normal_x     (rsp_normal_x),
      .rsp_normal_y     (rsp_normal_y),
      .rsp_normal_z     (rsp_normal_z),
      .rsp_status       (rsp_status)
   );

endmodule

`default_nettype wire

/* rtl/vna_checker.sv */
// Port-level checks for the vertex normal accumulator, bound to the top.
// Depends on vna_pkg and vertex_normal_accumulator_core.
`default_nettype none

module vna_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             full,
   input wire logic                             empty,
   input wire logic                             pop,
   input wire logic [vna_pkg::INDEX_W-1:0]      rsp_vertex_index,
   input wire logic signed [vna_pkg::NORMAL_W-1:0] rsp_normal_x,
   input wire logic signed [vna_pkg::NORMAL_W-1:0] rsp_normal_y,
   input wire logic signed [vna_pkg::NORMAL_W-1:0] rsp_normal_z,
   input wire logic [vna_pkg::STATUS_W-1:0]     rsp_status
);
   import vna_pkg::*;

   localparam logic [NORMAL_W-1:0] NORMAL_MIN = {1'b1, {(NORMAL_W-1){1'b0}}};

   // Reset empties the result queue and holds off input during the clear
   a_reset_state: assert property (@(posedge clock) reset |=> (empty && full))
      else $error("result queue not empty or input open after reset");

   // Failed or zero-length results carry a zero normal
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status != STATUS_OK) |->
      (rsp_normal_x == 0 && rsp_normal_y == 0 && rsp_normal_z == 0))
      else $error("nonzero normal on a failed result");

   // A good result has at least one nonzero component
   a_ok_nonzero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status == STATUS_OK) |->
      (rsp_normal_x != 0 || rsp_normal_y != 0 || rsp_normal_z != 0))
      else $error("all-zero normal with ok status");

   // Components stay within plus and minus 32767
   a_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_normal_x != NORMAL_MIN && rsp_normal_y != NORMAL_MIN &&
                  rsp_normal_z != NORMAL_MIN))
      else $error("normal component out of range");

   // A waiting result's vertex index and status hold until its transfer
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_vertex_index) && $stable(rsp_status)))
      else $error("waiting result changed before transfer");

endmodule

bind vertex_normal_accumulator_core vna_checker u_vna_checker (.*);

`default_nettype wire
